// ===== rtl/dhb_pkg.sv =====
// dhb_pkg: shared types, codes and reset constants for the dual h-bridge sequencer
// no dependencies; every rtl module of the block imports it

package dhb_pkg;

	localparam int SPD_W     = 7;
	localparam int DIR_W     = 2;
	localparam int OP_W      = 2;
	localparam int DUTY_W    = 10;
	localparam int TIMER_W   = 10;
	localparam int STEP_W    = 4;
	localparam int IVL_W     = 8;
	localparam int SETTLE_W  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 10;

	localparam int unsigned DUTY_FULL_SCALE_DEF = 999;
	localparam int unsigned PCT_FULL            = 100;
	localparam logic [SPD_W-1:0] SPD_LIMIT      = SPD_W'(PCT_FULL);

	// configuration reset values
	localparam logic [SPD_W-1:0]    KICK_SPEED_RST    = 7'd70;
	localparam logic [TIMER_W-1:0]  KICK_TICKS_RST    = 10'd300;
	localparam logic [STEP_W-1:0]   RAMP_STEP_RST     = 4'd2;
	localparam logic [IVL_W-1:0]    RAMP_INTERVAL_RST = 8'd20;
	localparam logic [SPD_W-1:0]    MIN_SPEED_RST     = 7'd15;
	localparam logic [SPD_W-1:0]    MAX_SPEED_RST     = 7'd85;
	localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST  = 8'd5;
	localparam logic [TIMER_W-1:0]  REVERSE_PAUSE_RST = 10'd100;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_SET   = 2'd3
	} op_t;

	// bit 0 drives pin 1, bit 1 drives pin 2
	typedef enum logic [DIR_W-1:0] {
		DIR_STOP  = 2'd0,
		DIR_FWD   = 2'd1,
		DIR_BACK  = 2'd2,
		DIR_BRAKE = 2'd3
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KICK_SPEED    = 3'd0,
		CFG_KICK_TICKS    = 3'd1,
		CFG_RAMP_STEP     = 3'd2,
		CFG_RAMP_INTERVAL = 3'd3,
		CFG_MIN_SPEED     = 3'd4,
		CFG_MAX_SPEED     = 3'd5,
		CFG_SETTLE_TICKS  = 3'd6,
		CFG_REVERSE_PAUSE = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_REV_SETTLE  = 3'd1,
		PH_REV_PAUSE   = 3'd2,
		PH_DIR_SETTLE  = 3'd3,
		PH_KICK        = 3'd4,
		PH_RAMP        = 3'd5,
		PH_STOP_SETTLE = 3'd6,
		PH_SET_SETTLE  = 3'd7
	} phase_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [DIR_W-1:0] dir_a;
		logic [DIR_W-1:0] dir_b;
		logic [SPD_W-1:0] speed_a;
		logic [SPD_W-1:0] speed_b;
	} item_t;

	typedef struct packed {
		logic              a_pin1;
		logic              a_pin2;
		logic              b_pin1;
		logic              b_pin2;
		logic [DUTY_W-1:0] duty_a;
		logic [DUTY_W-1:0] duty_b;
		logic              busy_res;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [SPD_W-1:0]    kick_speed;
		logic [TIMER_W-1:0]  kick_ticks;
		logic [STEP_W-1:0]   ramp_step;
		logic [IVL_W-1:0]    ramp_interval;
		logic [SPD_W-1:0]    min_speed;
		logic [SPD_W-1:0]    max_speed;
		logic [SETTLE_W-1:0] settle_ticks;
		logic [TIMER_W-1:0]  reverse_pause;
	} cfg_t;

	typedef struct packed {
		logic [DIR_W-1:0]   dir_a;
		logic [DIR_W-1:0]   dir_b;
		logic [SPD_W-1:0]   spd_a;
		logic [SPD_W-1:0]   spd_b;
		phase_t             phase;
		logic [TIMER_W-1:0] timer;
		logic [SPD_W-1:0]   level;
		logic [SPD_W-1:0]   target;
		logic [SPD_W-1:0]   pend_b;
		logic [2*DIR_W-1:0] pend_dirs;
	} seq_state_t;

endpackage

// ===== rtl/dhb_chan_if.sv =====
// dhb_chan_if: generic valid/ready channel with a typed payload
// no dependencies; payload type is chosen at instantiation

interface dhb_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/dual_hbridge_kick_ramp_sequencer.sv =====
// Dual h-bridge kick-start and ramp sequencer. Every transaction on item (a 1 ms tick or a
// start, stop or direct-set command) yields exactly one transaction on res holding the
// bridge pins, both pwm duties and the busy flag after that item. The block takes one item
// per clock unless res stalls: an input register feeds a single pass of sequencer logic that
// updates the motor state and loads the result register, and a new item may enter while a
// finished result still waits on res. Configuration is written through cfg_wr (always ready)
// and must only be changed while the block is idle.
// depends on dhb_pkg, dhb_chan_if, dhb_cfg_regs, dhb_seq_core, dhb_duty_lut

module dual_hbridge_kick_ramp_sequencer #(
	parameter int unsigned DUTY_FULL_SCALE = dhb_pkg::DUTY_FULL_SCALE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dhb_chan_if.sink   item,
	dhb_chan_if.source res,
	dhb_chan_if.sink   cfg_wr
);
	import dhb_pkg::*;

	cfg_t              cfg;
	item_t             item_s1;
	logic              valid_s1;
	result_t           res_s2;
	logic              valid_s2;
	logic              advance;
	seq_state_t        cur;
	seq_state_t        nxt;
	logic [DUTY_W-1:0] duty_a;
	logic [DUTY_W-1:0] duty_b;

	dhb_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.cfg    (cfg)
	);

	assign advance    = !valid_s2 || res.ready;
	assign item.ready = !valid_s1 || advance;

	dhb_seq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (valid_s1 && advance),
		.item   (item_s1),
		.cfg    (cfg),
		.cur    (cur),
		.nxt    (nxt)
	);

	dhb_duty_lut #(
		.DUTY_FULL_SCALE (DUTY_FULL_SCALE)
	) u_duty (
		.spd_a  (nxt.spd_a),
		.spd_b  (nxt.spd_b),
		.duty_a (duty_a),
		.duty_b (duty_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) valid_s1 <= item.valid;
			if (advance) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) item_s1 <= item.payload;
		if (advance && valid_s1) begin
			res_s2.a_pin1   <= nxt.dir_a[0];
			res_s2.a_pin2   <= nxt.dir_a[1];
			res_s2.b_pin1   <= nxt.dir_b[0];
			res_s2.b_pin2   <= nxt.dir_b[1];
			res_s2.duty_a   <= duty_a;
			res_s2.duty_b   <= duty_b;
			res_s2.busy_res <= (nxt.phase != PH_IDLE);
		end
	end

	assign res.valid   = valid_s2;
	assign res.payload = res_s2;

`ifndef SYNTHESIS
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> valid_s1)
		else $error("accepted item did not reach the input register");

	a_s2_load: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> valid_s2)
		else $error("processed item produced no result");

	a_chain_done: assert property (@(posedge clk) disable iff (!arst_n)
		cur.phase == PH_IDLE || cur.timer != '0)
		else $error("sequencer left an expired phase pending");
`endif

endmodule

// ===== rtl/dhb_cfg_regs.sv =====
// dhb_cfg_regs: configuration register file written through the cfg channel
// depends on dhb_pkg and dhb_chan_if

module dhb_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	dhb_chan_if.sink      cfg_wr,
	output dhb_pkg::cfg_t cfg
);
	import dhb_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign cfg_wr.ready = 1'b1;
	assign wr_en        = cfg_wr.valid && cfg_wr.ready;
	assign cfg          = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kick_speed    <= KICK_SPEED_RST;
			cfg_q.kick_ticks    <= KICK_TICKS_RST;
			cfg_q.ramp_step     <= RAMP_STEP_RST;
			cfg_q.ramp_interval <= RAMP_INTERVAL_RST;
			cfg_q.min_speed     <= MIN_SPEED_RST;
			cfg_q.max_speed     <= MAX_SPEED_RST;
			cfg_q.settle_ticks  <= SETTLE_TICKS_RST;
			cfg_q.reverse_pause <= REVERSE_PAUSE_RST;
		end else if (wr_en) begin
			unique case (cfg_wr.payload.index)
				CFG_KICK_SPEED:    cfg_q.kick_speed    <= cfg_wr.payload.data[SPD_W-1:0];
				CFG_KICK_TICKS:    cfg_q.kick_ticks    <= cfg_wr.payload.data[TIMER_W-1:0];
				CFG_RAMP_STEP:     cfg_q.ramp_step     <= cfg_wr.payload.data[STEP_W-1:0];
				CFG_RAMP_INTERVAL: cfg_q.ramp_interval <= cfg_wr.payload.data[IVL_W-1:0];
				CFG_MIN_SPEED:     cfg_q.min_speed     <= cfg_wr.payload.data[SPD_W-1:0];
				CFG_MAX_SPEED:     cfg_q.max_speed     <= cfg_wr.payload.data[SPD_W-1:0];
				CFG_SETTLE_TICKS:  cfg_q.settle_ticks  <= cfg_wr.payload.data[SETTLE_W-1:0];
				CFG_REVERSE_PAUSE: cfg_q.reverse_pause <= cfg_wr.payload.data[TIMER_W-1:0];
			endcase
		end
	end

endmodule

// ===== rtl/dhb_seq_core.sv =====
// dhb_seq_core: sequencer state register and per-transaction next-state logic
// depends on dhb_pkg

module dhb_seq_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  dhb_pkg::item_t      item,
	input  dhb_pkg::cfg_t       cfg,
	output dhb_pkg::seq_state_t cur,
	output dhb_pkg::seq_state_t nxt
);
	import dhb_pkg::*;

	// deepest chain of zero-length phases: rev settle, rev pause, dir settle, kick
	localparam int CHAIN_DEPTH = 4;

	seq_state_t st_q;
	seq_state_t st_d;

	function automatic logic [SPD_W-1:0] clamp_spd(logic [SPD_W-1:0] s, cfg_t c);
		logic [SPD_W-1:0] r;
		r = s;
		if (r > SPD_LIMIT) r = SPD_LIMIT;
		if (r != '0 && r < c.min_speed) r = c.min_speed;
		if (r > c.max_speed) r = c.max_speed;
		return r;
	endfunction

	function automatic seq_state_t end_phase(seq_state_t s, cfg_t c);
		seq_state_t        r;
		logic [STEP_W-1:0] st;
		logic [IVL_W-1:0]  ivl;
		logic [SPD_W-1:0]  lv;
		logic [SPD_W-1:0]  st_x;
		r    = s;
		st   = (c.ramp_step == '0) ? STEP_W'(1) : c.ramp_step;
		ivl  = (c.ramp_interval == '0) ? IVL_W'(1) : c.ramp_interval;
		st_x = {{(SPD_W-STEP_W){1'b0}}, st};
		lv   = s.level;
		unique case (s.phase)
			PH_REV_SETTLE: begin
				r.dir_a = DIR_STOP;
				r.dir_b = DIR_STOP;
				r.timer = c.reverse_pause;
				r.phase = PH_REV_PAUSE;
			end
			PH_REV_PAUSE: begin
				r.dir_a = s.pend_dirs[DIR_W-1:0];
				r.dir_b = s.pend_dirs[2*DIR_W-1:DIR_W];
				r.timer = {{(TIMER_W-SETTLE_W){1'b0}}, c.settle_ticks};
				r.phase = PH_DIR_SETTLE;
			end
			PH_DIR_SETTLE: begin
				r.spd_a = clamp_spd(c.kick_speed, c);
				r.spd_b = clamp_spd(c.kick_speed, c);
				r.level = c.kick_speed;
				r.timer = c.kick_ticks;
				r.phase = PH_KICK;
			end
			PH_KICK, PH_RAMP: begin
				if (s.level == s.target) begin
					r.phase = PH_IDLE;
				end else begin
					// saturating step toward the target
					if (s.level > s.target)
						lv = (s.level - s.target > st_x) ? s.level - st_x : s.target;
					else
						lv = (s.target - s.level > st_x) ? s.level + st_x : s.target;
					r.level = lv;
					r.spd_a = clamp_spd(lv, c);
					r.spd_b = clamp_spd(lv, c);
					r.timer = {{(TIMER_W-IVL_W){1'b0}}, ivl};
					r.phase = PH_RAMP;
				end
			end
			PH_STOP_SETTLE: begin
				r.dir_a = DIR_STOP;
				r.dir_b = DIR_STOP;
				r.phase = PH_IDLE;
			end
			PH_SET_SETTLE: begin
				r.spd_a = clamp_spd(s.target, c);
				r.spd_b = clamp_spd(s.pend_b, c);
				r.phase = PH_IDLE;
			end
			PH_IDLE: begin
				r.phase = PH_IDLE;
			end
		endcase
		return r;
	endfunction

	function automatic seq_state_t step_item(seq_state_t s, item_t it, cfg_t c);
		seq_state_t          r;
		logic                rev;
		logic [TIMER_W-1:0]  settle;
		r      = s;
		settle = {{(TIMER_W-SETTLE_W){1'b0}}, c.settle_ticks};
		rev    = (s.dir_a != it.dir_a && s.spd_a != '0) ||
		         (s.dir_b != it.dir_b && s.spd_b != '0);
		unique case (it.op)
			OP_TICK: begin
				if (s.phase != PH_IDLE && s.timer != '0) r.timer = s.timer - 1'b1;
			end
			OP_START: begin
				r.target    = it.speed_a;
				r.pend_dirs = {it.dir_b, it.dir_a};
				r.timer     = settle;
				if (rev) begin
					r.spd_a = '0;
					r.spd_b = '0;
					r.phase = PH_REV_SETTLE;
				end else begin
					r.dir_a = it.dir_a;
					r.dir_b = it.dir_b;
					r.phase = PH_DIR_SETTLE;
				end
			end
			OP_STOP: begin
				r.spd_a = '0;
				r.spd_b = '0;
				r.timer = settle;
				r.phase = PH_STOP_SETTLE;
			end
			OP_SET: begin
				r.target    = it.speed_a;
				r.pend_b    = it.speed_b;
				r.pend_dirs = {it.dir_b, it.dir_a};
				r.dir_a     = it.dir_a;
				r.dir_b     = it.dir_b;
				r.timer     = settle;
				r.phase     = PH_SET_SETTLE;
			end
		endcase
		// phases whose wait has run out end within the same transaction
		for (int i = 0; i < CHAIN_DEPTH; i++) begin
			if (r.phase != PH_IDLE && r.timer == '0) r = end_phase(r, c);
		end
		return r;
	endfunction

	always_comb begin
		st_d = st_q;
		if (upd) st_d = step_item(st_q, item, cfg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.dir_a     <= DIR_STOP;
			st_q.dir_b     <= DIR_STOP;
			st_q.spd_a     <= '0;
			st_q.spd_b     <= '0;
			st_q.phase     <= PH_IDLE;
			st_q.timer     <= '0;
			st_q.level     <= '0;
			st_q.target    <= '0;
			st_q.pend_b    <= '0;
			st_q.pend_dirs <= '0;
		end else begin
			st_q <= st_d;
		end
	end

	assign cur = st_q;
	assign nxt = st_d;

endmodule

// ===== rtl/dhb_duty_lut.sv =====
// dhb_duty_lut: percent speed to pwm duty through a constant table
// depends on dhb_pkg; table contents follow the full-scale parameter

module dhb_duty_lut #(
	parameter int unsigned DUTY_FULL_SCALE = dhb_pkg::DUTY_FULL_SCALE_DEF
) (
	input  logic [dhb_pkg::SPD_W-1:0]  spd_a,
	input  logic [dhb_pkg::SPD_W-1:0]  spd_b,
	output logic [dhb_pkg::DUTY_W-1:0] duty_a,
	output logic [dhb_pkg::DUTY_W-1:0] duty_b
);
	import dhb_pkg::*;

	localparam int LUT_N = 1 << SPD_W;

	logic [DUTY_W-1:0] lut [LUT_N];

	// entries are elaboration constants; high bits beyond the duty field drop off
	for (genvar i = 0; i < LUT_N; i++) begin : g_lut
		assign lut[i] = DUTY_W'((i * DUTY_FULL_SCALE) / PCT_FULL);
	end

	assign duty_a = lut[spd_a];
	assign duty_b = lut[spd_b];

endmodule

// ===== bench/dual_hbridge_kick_ramp_sequencer_tb.sv =====
// dual_hbridge_kick_ramp_sequencer_tb: self-checking bench for the dual h-bridge sequencer
// a directed table, then randomized command/tick sequences over several register settings
// depends on dhb_pkg, dhb_chan_if and the rtl of dual_hbridge_kick_ramp_sequencer
`timescale 1ns / 100ps

module dual_hbridge_kick_ramp_sequencer_tb;
	import dhb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 205;
	localparam int NUM_PHASES     = 9;

	typedef enum int {PROF_FAST, PROF_ZERO, PROF_MAX, PROF_SWAP, PROF_WILD} profile_t;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	dhb_chan_if #(.T(item_t))   item_if ();
	dhb_chan_if #(.T(result_t)) res_if ();
	dhb_chan_if #(.T(cfg_wr_t)) cfg_if ();

	dual_hbridge_kick_ramp_sequencer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_if),
		.res     (res_if),
		.cfg_wr  (cfg_if)
	);

	// mirror of the sequencer
	cfg_t             shadow_cfg;
	dir_t             mot_dir_a, mot_dir_b;
	logic [SPD_W-1:0] mot_spd_a, mot_spd_b;
	phase_t           seq_ph;
	logic [TIMER_W-1:0] ph_timer;
	logic [SPD_W-1:0] ramp_lvl, tgt_spd, pend_spd_b;
	logic [2*DIR_W-1:0] pend_dir;

	result_t exp_outputs[$];
	int      n_errors;
	int      send_gap_pct;
	int      recv_stall_pct;
	int      quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [SPD_W-1:0] limit_speed(input logic [SPD_W-1:0] s);
		logic [SPD_W-1:0] v;
		v = s;
		if (v > SPD_LIMIT) v = SPD_LIMIT;
		if (v != 0 && v < shadow_cfg.min_speed) v = shadow_cfg.min_speed;
		if (v > shadow_cfg.max_speed) v = shadow_cfg.max_speed;
		return v;
	endfunction

	function automatic logic [DUTY_W-1:0] to_duty(input logic [SPD_W-1:0] s);
		int unsigned prod;
		prod = s;
		prod = prod * DUTY_FULL_SCALE_DEF / PCT_FULL;
		return prod[DUTY_W-1:0];
	endfunction

	task automatic reset_mirror();
		shadow_cfg.kick_speed    = KICK_SPEED_RST;
		shadow_cfg.kick_ticks    = KICK_TICKS_RST;
		shadow_cfg.ramp_step     = RAMP_STEP_RST;
		shadow_cfg.ramp_interval = RAMP_INTERVAL_RST;
		shadow_cfg.min_speed     = MIN_SPEED_RST;
		shadow_cfg.max_speed     = MAX_SPEED_RST;
		shadow_cfg.settle_ticks  = SETTLE_TICKS_RST;
		shadow_cfg.reverse_pause = REVERSE_PAUSE_RST;
		mot_dir_a  = DIR_STOP;
		mot_dir_b  = DIR_STOP;
		mot_spd_a  = '0;
		mot_spd_b  = '0;
		seq_ph     = PH_IDLE;
		ph_timer   = '0;
		ramp_lvl   = '0;
		tgt_spd    = '0;
		pend_spd_b = '0;
		pend_dir   = '0;
	endtask

	task automatic set_both(input logic [SPD_W-1:0] s);
		mot_spd_a = limit_speed(s);
		mot_spd_b = limit_speed(s);
	endtask

	task automatic ramp_toward_target();
		int st;
		int lv;
		int tg;
		st = (shadow_cfg.ramp_step == 0) ? 1 : shadow_cfg.ramp_step;
		lv = ramp_lvl;
		tg = tgt_spd;
		if (lv > tg) lv = (lv - tg > st) ? lv - st : tg;
		else lv = (tg - lv > st) ? lv + st : tg;
		ramp_lvl = lv[SPD_W-1:0];
		set_both(ramp_lvl);
		ph_timer = (shadow_cfg.ramp_interval == 0) ? TIMER_W'(1)
			: TIMER_W'(shadow_cfg.ramp_interval);
		seq_ph = PH_RAMP;
	endtask

	task automatic finish_phase();
		case (seq_ph)
			PH_REV_SETTLE: begin
				mot_dir_a = DIR_STOP;
				mot_dir_b = DIR_STOP;
				ph_timer = shadow_cfg.reverse_pause;
				seq_ph = PH_REV_PAUSE;
			end
			PH_REV_PAUSE: begin
				mot_dir_a = dir_t'(pend_dir[1:0]);
				mot_dir_b = dir_t'(pend_dir[3:2]);
				ph_timer = TIMER_W'(shadow_cfg.settle_ticks);
				seq_ph = PH_DIR_SETTLE;
			end
			PH_DIR_SETTLE: begin
				set_both(shadow_cfg.kick_speed);
				ramp_lvl = shadow_cfg.kick_speed;
				ph_timer = shadow_cfg.kick_ticks;
				seq_ph = PH_KICK;
			end
			PH_KICK, PH_RAMP: begin
				if (ramp_lvl == tgt_spd) seq_ph = PH_IDLE;
				else ramp_toward_target();
			end
			PH_STOP_SETTLE: begin
				mot_dir_a = DIR_STOP;
				mot_dir_b = DIR_STOP;
				seq_ph = PH_IDLE;
			end
			PH_SET_SETTLE: begin
				mot_spd_a = limit_speed(tgt_spd);
				mot_spd_b = limit_speed(pend_spd_b);
				seq_ph = PH_IDLE;
			end
			default: seq_ph = PH_IDLE;
		endcase
	endtask

	// one item in, the bridge outputs after it out
	task automatic advance_motors(input item_t it, output result_t r);
		dir_t da;
		dir_t db;
		bit   rev;
		da = dir_t'(it.dir_a);
		db = dir_t'(it.dir_b);
		case (op_t'(it.op))
			OP_TICK: begin
				if (seq_ph != PH_IDLE && ph_timer > 0) ph_timer = ph_timer - 1'b1;
			end
			OP_START: begin
				rev = (mot_dir_a != da && mot_spd_a > 0) ||
					(mot_dir_b != db && mot_spd_b > 0);
				tgt_spd = it.speed_a;
				pend_dir = {db, da};
				ph_timer = TIMER_W'(shadow_cfg.settle_ticks);
				if (rev) begin
					set_both('0);
					seq_ph = PH_REV_SETTLE;
				end else begin
					mot_dir_a = da;
					mot_dir_b = db;
					seq_ph = PH_DIR_SETTLE;
				end
			end
			OP_STOP: begin
				set_both('0);
				ph_timer = TIMER_W'(shadow_cfg.settle_ticks);
				seq_ph = PH_STOP_SETTLE;
			end
			default: begin
				tgt_spd = it.speed_a;
				pend_spd_b = it.speed_b;
				pend_dir = {db, da};
				mot_dir_a = da;
				mot_dir_b = db;
				ph_timer = TIMER_W'(shadow_cfg.settle_ticks);
				seq_ph = PH_SET_SETTLE;
			end
		endcase
		// zero-length waits fall through several phases in one item
		for (int g = 0; g < 16; g++) begin
			if (seq_ph == PH_IDLE || ph_timer != 0) break;
			finish_phase();
		end
		r.a_pin1   = (mot_dir_a == DIR_FWD || mot_dir_a == DIR_BRAKE);
		r.a_pin2   = (mot_dir_a == DIR_BACK || mot_dir_a == DIR_BRAKE);
		r.b_pin1   = (mot_dir_b == DIR_FWD || mot_dir_b == DIR_BRAKE);
		r.b_pin2   = (mot_dir_b == DIR_BACK || mot_dir_b == DIR_BRAKE);
		r.duty_a   = to_duty(mot_spd_a);
		r.duty_b   = to_duty(mot_spd_b);
		r.busy_res = (seq_ph != PH_IDLE);
	endtask

	task automatic apply_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] d);
		case (idx)
			CFG_KICK_SPEED:    shadow_cfg.kick_speed    = d[SPD_W-1:0];
			CFG_KICK_TICKS:    shadow_cfg.kick_ticks    = d[TIMER_W-1:0];
			CFG_RAMP_STEP:     shadow_cfg.ramp_step     = d[STEP_W-1:0];
			CFG_RAMP_INTERVAL: shadow_cfg.ramp_interval = d[IVL_W-1:0];
			CFG_MIN_SPEED:     shadow_cfg.min_speed     = d[SPD_W-1:0];
			CFG_MAX_SPEED:     shadow_cfg.max_speed     = d[SPD_W-1:0];
			CFG_SETTLE_TICKS:  shadow_cfg.settle_ticks  = d[SETTLE_W-1:0];
			default:           shadow_cfg.reverse_pause = d[TIMER_W-1:0];
		endcase
	endtask

	// entered and left at a falling edge; valid is left high
	task automatic push_item(input item_t it, input bit typed = 1'b0, input result_t want = '0);
		result_t r;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_if.valid = 1'b0;
			@(negedge clk);
		end
		item_if.valid = 1'b1;
		item_if.payload = it;
		do @(posedge clk); while (!item_if.ready);
		advance_motors(it, r);
		exp_outputs.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] d);
		cfg_if.valid = 1'b1;
		cfg_if.payload = {idx, d};
		do @(posedge clk); while (!cfg_if.ready);
		apply_reg(idx, d);
		@(negedge clk);
	endtask

	task automatic drain_results();
		item_if.valid = 1'b0;
		do @(negedge clk); while (exp_outputs.size() != 0);
	endtask

	function automatic logic [SPD_W-1:0] rand_speed();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SPD_W'($urandom_range(101, 127));
			2: return SPD_LIMIT;
			default: return SPD_W'($urandom_range(1, 99));
		endcase
	endfunction

	function automatic item_t rand_item(input op_t op);
		item_t it;
		it.op      = op;
		it.dir_a   = DIR_W'($urandom_range(0, 3));
		it.dir_b   = DIR_W'($urandom_range(0, 3));
		it.speed_a = rand_speed();
		it.speed_b = rand_speed();
		return it;
	endfunction

	function automatic stim_row_t row(input op_t op, input dir_t da, input dir_t db,
			input int sa, input int sb, input bit typed = 1'b0, input result_t want = '0);
		stim_row_t s;
		s.it = {op, da, db, SPD_W'(sa), SPD_W'(sb)};
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	// stop whatever runs and tick until the sequencer is idle
	task automatic bring_to_idle();
		if (seq_ph != PH_IDLE) push_item(rand_item(OP_STOP));
		while (seq_ph != PH_IDLE) push_item(rand_item(OP_TICK));
	endtask

	task automatic program_setting(input profile_t kind);
		logic [CFG_DAT_W-1:0] val [8];
		for (int i = 0; i < 8; i++) val[i] = '0;
		case (kind)
			PROF_FAST, PROF_SWAP: begin
				val[CFG_KICK_SPEED]    = CFG_DAT_W'($urandom_range(0, 100));
				val[CFG_KICK_TICKS]    = CFG_DAT_W'($urandom_range(0, 12));
				val[CFG_RAMP_STEP]     = CFG_DAT_W'($urandom_range(0, 15));
				val[CFG_RAMP_INTERVAL] = CFG_DAT_W'($urandom_range(0, 4));
				val[CFG_SETTLE_TICKS]  = CFG_DAT_W'($urandom_range(0, 4));
				val[CFG_REVERSE_PAUSE] = CFG_DAT_W'($urandom_range(0, 6));
				if (kind == PROF_SWAP) begin
					// min above max, max clamp wins
					val[CFG_MIN_SPEED] = CFG_DAT_W'($urandom_range(50, 100));
					val[CFG_MAX_SPEED] = CFG_DAT_W'($urandom_range(0, 49));
				end else begin
					val[CFG_MIN_SPEED] = CFG_DAT_W'($urandom_range(0, 40));
					val[CFG_MAX_SPEED] = CFG_DAT_W'($urandom_range(50, 100));
				end
			end
			PROF_ZERO: begin
				val[CFG_KICK_SPEED] = CFG_DAT_W'($urandom_range(0, 100));
				val[CFG_MAX_SPEED]  = CFG_DAT_W'(100);
			end
			PROF_MAX: begin
				for (int i = 0; i < 8; i++) val[i] = '1;
			end
			default: begin
				for (int i = 0; i < 8; i++) val[i] = CFG_DAT_W'($urandom_range(0, 1023));
			end
		endcase
		for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), val[i]);
		cfg_if.valid = 1'b0;
	endtask

	task automatic run_directed();
		stim_row_t tab[$];
		tab.push_back(row(OP_TICK, DIR_STOP, DIR_STOP, 0, 0, 1'b1, '0));
		tab.push_back(row(OP_SET, DIR_FWD, DIR_BACK, 100, 0, 1'b1,
			{1'b1, 1'b0, 1'b0, 1'b1, 10'd0, 10'd0, 1'b1}));
		for (int i = 0; i < 4; i++) tab.push_back(row(OP_TICK, DIR_STOP, DIR_STOP, 0, 0));
		tab.push_back(row(OP_TICK, DIR_STOP, DIR_STOP, 0, 0, 1'b1,
			{1'b1, 1'b0, 1'b0, 1'b1, 10'd849, 10'd0, 1'b0}));
		tab.push_back(row(OP_TICK, DIR_BRAKE, DIR_BRAKE, 127, 127));
		// reversal on a running motor, then abandoned by a stop
		tab.push_back(row(OP_START, DIR_BACK, DIR_BACK, 127, 0));
		tab.push_back(row(OP_STOP, DIR_STOP, DIR_STOP, 0, 0));
		for (int i = 0; i < 4; i++) tab.push_back(row(OP_TICK, DIR_STOP, DIR_STOP, 0, 0));
		tab.push_back(row(OP_TICK, DIR_STOP, DIR_STOP, 0, 0, 1'b1, '0));
		tab.push_back(row(OP_SET, DIR_BRAKE, DIR_BRAKE, 1, 127));
		for (int i = 0; i < 4; i++) tab.push_back(row(OP_TICK, DIR_STOP, DIR_STOP, 0, 0));
		tab.push_back(row(OP_TICK, DIR_STOP, DIR_STOP, 0, 0, 1'b1,
			{1'b1, 1'b1, 1'b1, 1'b1, 10'd149, 10'd849, 1'b0}));
		tab.push_back(row(OP_START, DIR_BRAKE, DIR_BRAKE, 0, 0));
		tab.push_back(row(OP_START, DIR_FWD, DIR_STOP, 50, 0));
		tab.push_back(row(OP_SET, DIR_STOP, DIR_STOP, 0, 0));
		tab.push_back(row(OP_TICK, DIR_STOP, DIR_STOP, 0, 0));
		foreach (tab[i]) push_item(tab[i].it, tab[i].typed, tab[i].want);
	endtask

	task automatic random_phase(input int budget);
		int   sent;
		int   span;
		int   pick;
		op_t  op;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 19);
			if (pick < 10) op = OP_START;
			else if (pick < 15) op = OP_SET;
			else if (pick < 18) op = OP_STOP;
			else op = OP_TICK;
			push_item(rand_item(op));
			sent++;
			if ($urandom_range(0, 9) < 6) begin
				// let the sequence run to its end
				while (seq_ph != PH_IDLE && sent < budget) begin
					push_item(rand_item(OP_TICK));
					sent++;
				end
				span = $urandom_range(0, 2);
			end else begin
				span = $urandom_range(0, 30);
			end
			for (int i = 0; i < span && sent < budget; i++) begin
				push_item(rand_item(OP_TICK));
				sent++;
			end
			if ($urandom_range(0, 29) == 0) drain_results();
		end
	endtask

	task automatic check_outputs(input result_t got, input result_t want);
		if (got.a_pin1 !== want.a_pin1) begin
			$error("a_pin1: expected %0d, actual %0d", want.a_pin1, got.a_pin1);
			n_errors++;
		end
		if (got.a_pin2 !== want.a_pin2) begin
			$error("a_pin2: expected %0d, actual %0d", want.a_pin2, got.a_pin2);
			n_errors++;
		end
		if (got.b_pin1 !== want.b_pin1) begin
			$error("b_pin1: expected %0d, actual %0d", want.b_pin1, got.b_pin1);
			n_errors++;
		end
		if (got.b_pin2 !== want.b_pin2) begin
			$error("b_pin2: expected %0d, actual %0d", want.b_pin2, got.b_pin2);
			n_errors++;
		end
		if (got.duty_a !== want.duty_a) begin
			$error("duty_a: expected %0d, actual %0d", want.duty_a, got.duty_a);
			n_errors++;
		end
		if (got.duty_b !== want.duty_b) begin
			$error("duty_b: expected %0d, actual %0d", want.duty_b, got.duty_b);
			n_errors++;
		end
		if (got.busy_res !== want.busy_res) begin
			$error("busy_res: expected %0d, actual %0d", want.busy_res, got.busy_res);
			n_errors++;
		end
	endtask

	// receiver side
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (exp_outputs.size() == 0) begin
					$error("result transaction with nothing expected");
					n_errors++;
				end else begin
					check_outputs(res_if.payload, exp_outputs.pop_front());
				end
			end
			if ((res_if.valid && res_if.ready) || (item_if.valid && item_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		profile_t plan [NUM_PHASES];
		plan = '{PROF_FAST, PROF_ZERO, PROF_MAX, PROF_SWAP, PROF_FAST, PROF_WILD,
			PROF_FAST, PROF_ZERO, PROF_FAST};
		n_errors = 0;
		quiet_cycles = 0;
		send_gap_pct = 23;
		recv_stall_pct = 69;
		item_if.valid = 1'b0;
		item_if.payload = '0;
		cfg_if.valid = 1'b0;
		cfg_if.payload = '0;
		reset_mirror();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p / 3)
				0: begin
					send_gap_pct = 23;
					recv_stall_pct = 69;
				end
				1: begin
					send_gap_pct = 69;
					recv_stall_pct = 23;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			// registers only change with the sequencer idle and no transaction in flight
			bring_to_idle();
			drain_results();
			program_setting(plan[p]);
			random_phase(PHASE_ITEMS);
		end

		item_if.valid = 1'b0;
		while (exp_outputs.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
